// ===== hdl/ypf_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte update of the YMODEM packet framer.
// No dependencies; imported by ypf_framer and the top level.
package ypf_pkg;

  // Data bytes in one packet (128 for classic blocks, up to 1024 for 1K blocks).
  localparam int unsigned PayloadBytes = 128;

  localparam int PosWidth  = 10;
  localparam int MaxResult = 4;
  localparam int CntWidth  = $clog2(MaxResult + 1);
  localparam int IdxWidth  = $clog2(MaxResult);

  localparam logic [7:0]  ByteSoh = 8'h01;
  localparam logic [7:0]  ByteStx = 8'h02;
  localparam logic [7:0]  ByteEot = 8'h04;
  localparam logic [7:0]  BytePad = 8'h1A;
  localparam logic [7:0]  ByteZeroPad = 8'h00;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  ByteHeader = (PayloadBytes > 128) ? ByteStx : ByteSoh;
  localparam logic [PosWidth:0] PosLast = (PosWidth + 1)'(PayloadBytes);

  typedef enum logic [2:0] {
    CMD_PAYLOAD = 3'd0,
    CMD_PAD     = 3'd1,
    CMD_ACK     = 3'd2,
    CMD_RETRY   = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_EOT     = 3'd5
  } cmd_e;

  // Result bytes of one item, in transmit order.
  typedef struct packed {
    logic [CntWidth-1:0]            cnt;
    logic [MaxResult-1:0][7:0]      bytes;
    logic [MaxResult-1:0]           ends;
  } frame_res_t;

  // Fold one byte into a CRC-16/XMODEM (no reflection, no final xor).
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== hdl/ypf_framer.sv =====
// Packet state (position, block number, running CRC) and result byte generation.
// Depends on ypf_pkg.
module ypf_framer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [2:0]               cmd_i,
  input  logic [7:0]               payload_byte_i,
  output ypf_pkg::frame_res_t      res_o
);
  import ypf_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          blk_q, blk_d;
  logic [15:0]         crc_q, crc_d;

  logic [7:0]          data_byte;
  logic [15:0]         crc_base;
  logic [15:0]         crc_new;
  logic [PosWidth:0]   pos_inc;
  logic                pkt_last;

  assign data_byte = (cmd_i == CMD_PAYLOAD) ? payload_byte_i :
                     ((blk_q == 8'd0) ? ByteZeroPad : BytePad);
  assign crc_base  = (pos_q == '0) ? 16'h0000 : crc_q;
  assign crc_new   = crc_update(crc_base, data_byte);
  assign pos_inc   = {1'b0, pos_q} + (PosWidth + 1)'(1);
  assign pkt_last  = (pos_inc >= PosLast);

  always_comb begin
    res_o = '0;
    pos_d = pos_q;
    blk_d = blk_q;
    crc_d = crc_q;
    unique case (cmd_i)
      CMD_PAYLOAD, CMD_PAD: begin
        if (pos_q == '0) begin
          res_o.bytes[0] = ByteHeader;
          res_o.bytes[1] = blk_q;
          res_o.bytes[2] = ~blk_q;
          res_o.bytes[3] = data_byte;
          res_o.cnt      = CntWidth'(4);
        end else if (pkt_last) begin
          res_o.bytes[0] = data_byte;
          res_o.bytes[1] = crc_new[15:8];
          res_o.bytes[2] = crc_new[7:0];
          res_o.ends[2]  = 1'b1;
          res_o.cnt      = CntWidth'(3);
        end else begin
          res_o.bytes[0] = data_byte;
          res_o.cnt      = CntWidth'(1);
        end
        pos_d = pkt_last ? '0 : pos_inc[PosWidth-1:0];
        crc_d = pkt_last ? 16'h0000 : crc_new;
      end
      CMD_ACK: begin
        blk_d = blk_q + 8'd1;
        pos_d = '0;
        crc_d = 16'h0000;
      end
      CMD_RETRY: begin
        pos_d = '0;
        crc_d = 16'h0000;
      end
      CMD_RESTART: begin
        blk_d = 8'd0;
        pos_d = '0;
        crc_d = 16'h0000;
      end
      CMD_EOT: begin
        res_o.bytes[0] = ByteEot;
        res_o.ends[0]  = 1'b1;
        res_o.cnt      = CntWidth'(1);
        pos_d = '0;
        crc_d = 16'h0000;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      blk_q <= '0;
      crc_q <= '0;
    end else if (load_i) begin
      pos_q <= pos_d;
      blk_q <= blk_d;
      crc_q <= crc_d;
    end
  end

endmodule

// ===== hdl/ymodem_packet_framer_top.sv =====
// Top level of the YMODEM packet framer: input register, framer, result buffer.
// Depends on ypf_pkg and ypf_framer.
//
// Each item (a payload or pad byte, or a command) is taken into an input register,
// turned into zero to four transmit bytes by the combinational framer, and those bytes
// are held in a four-entry result buffer that drives the output one byte a cycle while
// out_stall_i is low. An item that yields at most one byte flows at one item per cycle
// while the output is not stalled; the item that opens a packet (header of three bytes
// plus its data byte) and the one that closes it (data byte plus two CRC bytes) make
// the next item wait in the input register until the single-byte output port has
// drained the buffer. Ack, retry and restart produce no bytes.
module ymodem_packet_framer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] payload_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       frame_end_o
);
  import ypf_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [2:0] cmd_q;
  logic [7:0] byte_q;

  // Result buffer: entries, fill count and read index.
  logic [MaxResult-1:0][7:0] buf_bytes_q;
  logic [MaxResult-1:0]      buf_ends_q;
  logic [CntWidth-1:0]       cnt_q;
  logic [IdxWidth-1:0]       rd_q;

  frame_res_t res;
  logic       in_acc;
  logic       out_acc;
  logic       move;

  assign out_acc = out_valid_o && !out_stall_i;
  // Hand the held item to the framer once the buffer is empty or its last byte leaves.
  assign move    = in_vld_q && ((cnt_q == '0) ||
                                ((cnt_q == CntWidth'(1)) && out_acc));
  assign in_stall_o = in_vld_q && !move;
  assign in_acc     = in_valid_i && !in_stall_o;

  ypf_framer u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (move),
    .cmd_i          (cmd_q),
    .payload_byte_i (byte_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  // Payload of the input register; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      byte_q <= payload_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (move) begin
      cnt_q <= res.cnt;
      rd_q  <= '0;
    end else if (out_acc) begin
      cnt_q <= cnt_q - CntWidth'(1);
      rd_q  <= rd_q + IdxWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      buf_bytes_q <= res.bytes;
      buf_ends_q  <= res.ends;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign tx_byte_o   = buf_bytes_q[rd_q];
  assign frame_end_o = buf_ends_q[rd_q];

endmodule

// ===== hdl/ypf_checker.sv =====
// Port-level checks of the YMODEM packet framer, bound to the top level.
// Depends on ymodem_packet_framer_top.
module ypf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       frame_end_o
);

  // Input only backs up behind bytes still waiting at the output.
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  // With the output held, a stalled input stays stalled.
  a_stall_persists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_stall_i ##1 out_stall_i |-> in_stall_o)
    else $error("input released while output stayed blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(tx_byte_o) && $stable(frame_end_o))
    else $error("stalled output item changed");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output valid dropped without accept");

endmodule

bind ymodem_packet_framer_top ypf_checker u_ypf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .tx_byte_o   (tx_byte_o),
  .frame_end_o (frame_end_o)
);
